// ===== rtl/bgi_pkg.sv =====
`default_nettype none
package bgi_pkg;

    localparam int MAX_TEMPS     = 32;
    localparam int MAX_PRESSURES = 64;
    localparam int ADDR_W        = 11;
    localparam int STORE_DEPTH   = 2048;
    localparam int VAL_W         = 16;
    localparam int ENTRY_W       = 3 * VAL_W;
    localparam int NT_W          = 6;
    localparam int NP_W          = 7;
    localparam int ROW_W         = $clog2(MAX_TEMPS);
    localparam int COL_W         = $clog2(MAX_PRESSURES);
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int STAT_W        = 2;

    localparam logic [CFG_IDX_W-1:0] IDX_NUM_TEMPS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] IDX_NUM_PRESSURES = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TEMP  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW0_RD,
        ST_ROW0_CAP,
        ST_ROW_RD,
        ST_ROW_CHK,
        ST_COL0_RD,
        ST_COL0_CAP,
        ST_COL_RD,
        ST_COL_CHK,
        ST_UPA_RD,
        ST_UPA_CAP,
        ST_UPB_RD,
        ST_UPB_CAP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/bgi_if.sv =====
`default_nettype none
interface bgi_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [10:0] entry_index;
    logic [15:0] grid_temperature;
    logic [15:0] grid_pressure;
    logic [15:0] grid_density;
    logic [15:0] query_temperature;
    logic [15:0] query_pressure;

    modport source (output valid, func, entry_index, grid_temperature, grid_pressure,
                    grid_density, query_temperature, query_pressure, input ready);
    modport sink (input valid, func, entry_index, grid_temperature, grid_pressure,
                  grid_density, query_temperature, query_pressure, output ready);
endinterface

interface bgi_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] density_out;
    logic [1:0]  status;

    modport source (output valid, density_out, status, input ready);
    modport sink (input valid, density_out, status, output ready);
endinterface

interface bgi_cfg_if;
    logic       valid;
    logic       ready;
    logic       reg_index;
    logic [6:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink (input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bilinear_grid_interpolation.sv =====
// density lookup over a loaded (temperature, pressure, density) grid
// channels: i_in takes words; func load writes one grid entry at entry_index
// and gives no result; func query gives one word on o_out with the bilinear
// density and a status (ok, pressure or temperature outside)
// i_cfg writes num_temps (index 0) and num_pressures (index 1); the user must
// write them only when idle; the block itself does not enforce this
// a query walks the grid memory one read at a time: it reads the first row's
// temperature, then each temperature row tried, then each pressure column
// tried, then the upper row's entries, then runs 8 multiply steps and 16
// divide steps, then hands the word over to the output register
// loads and queries are taken one at a time while the block is idle; the
// single-port-read grid memory and the shared multiplier set the query length
// a finished word sits in the output register; the next word is accepted
// while it waits, and a query stalls in its last step until the output frees
// reset clears the sequencer and the output valid and sets both sizes to 2;
// grid contents are undefined until loaded
`default_nettype none
module bilinear_grid_interpolation
    import bgi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bgi_in_if.sink     i_in,
    bgi_cfg_if.sink    i_cfg,
    bgi_out_if.source  o_out
);
    t_state r_state, n_state;

    logic [NT_W-1:0]   r_num_temps, r_nt;
    logic [NP_W-1:0]   r_num_pressures, r_np;
    logic [VAL_W-1:0]  r_qt, r_qp, r_t1, r_t2, r_p1, r_p2;
    logic [VAL_W-1:0]  r_da, r_db, r_dc, r_dd;
    logic [ADDR_W-1:0] r_base, r_a;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_last, r_tlin, r_plin;
    logic [2:0]        r_step;
    logic [3:0]        r_dcnt;
    logic [32:0]       r_s;
    logic [50:0]       r_acc, r_num, r_dv;
    logic [31:0]       r_den;
    logic [VAL_W-1:0]  r_q;
    logic [VAL_W-1:0]  r_res_d;
    logic [STAT_W-1:0] r_res_s;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_d;
    logic [STAT_W-1:0] r_out_s;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [VAL_W-1:0]  rd_t, rd_p, rd_d;
    logic [ADDR_W-1:0] np_ext;
    logic              in_acc, t_hit, p_hit, row_more, col_more, out_free;
    logic [VAL_W-1:0]  wt1, wt2, tden, wp1, wp2, pden;
    logic [32:0]       mul_x;
    logic [VAL_W-1:0]  mul_y;
    logic [48:0]       prod;
    logic              div_ge;
    logic [NT_W-1:0]   nt_clamp;
    logic [NP_W-1:0]   np_clamp;

    assign in_acc   = i_in.valid && i_in.ready;
    assign ram_we   = in_acc && (i_in.func == FUNC_LOAD);
    assign rd_t     = ram_rdata[3*VAL_W-1:2*VAL_W];
    assign rd_p     = ram_rdata[2*VAL_W-1:VAL_W];
    assign rd_d     = ram_rdata[VAL_W-1:0];
    assign np_ext   = ADDR_W'(r_np);
    assign t_hit    = (r_qt >= r_t1) && (r_qt < rd_t);
    assign p_hit    = (r_qp >= r_p1) && (r_qp < rd_p);
    assign row_more = (NT_W'({1'b0, r_row}) + NT_W'(2)) < r_nt;
    assign col_more = (NP_W'({1'b0, r_col}) + NP_W'(2)) < r_np;
    assign out_free = !r_out_valid || o_out.ready;

    assign nt_clamp = (r_num_temps < NT_W'(2)) ? NT_W'(2) :
                      (r_num_temps > NT_W'(MAX_TEMPS)) ? NT_W'(MAX_TEMPS) : r_num_temps;
    assign np_clamp = (r_num_pressures < NP_W'(2)) ? NP_W'(2) :
                      (r_num_pressures > NP_W'(MAX_PRESSURES)) ? NP_W'(MAX_PRESSURES) :
                      r_num_pressures;

    // a missing axis gets weight one on the lower point and zero on the upper
    assign wt1  = r_tlin ? VAL_W'(1) : r_t2 - r_qt;
    assign wt2  = r_tlin ? '0 : r_qt - r_t1;
    assign tden = r_tlin ? VAL_W'(1) : r_t2 - r_t1;
    assign wp1  = r_plin ? VAL_W'(1) : r_p2 - r_qp;
    assign wp2  = r_plin ? '0 : r_qp - r_p1;
    assign pden = r_plin ? VAL_W'(1) : r_p2 - r_p1;

    always_comb begin
        case (r_step)
            3'd0:    begin mul_x = 33'(r_da); mul_y = wt1;  end
            3'd1:    begin mul_x = 33'(r_dc); mul_y = wt2;  end
            3'd2:    begin mul_x = r_s;       mul_y = wp1;  end
            3'd3:    begin mul_x = 33'(r_db); mul_y = wt1;  end
            3'd4:    begin mul_x = 33'(r_dd); mul_y = wt2;  end
            3'd5:    begin mul_x = r_s;       mul_y = wp2;  end
            default: begin mul_x = 33'(tden); mul_y = pden; end
        endcase
    end
    assign prod   = 49'(mul_x) * 49'(mul_y);
    assign div_ge = r_num >= r_dv;

    bgi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in.entry_index),
        .i_wdata ({i_in.grid_temperature, i_in.grid_pressure, i_in.grid_density}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_acc && i_in.func == FUNC_QUERY) n_state = ST_ROW0_RD;
            ST_ROW0_RD:  n_state = ST_ROW0_CAP;
            ST_ROW0_CAP: n_state = ST_ROW_RD;
            ST_ROW_RD:   n_state = ST_ROW_CHK;
            ST_ROW_CHK: begin
                if (t_hit)               n_state = ST_COL0_RD;
                else if (row_more)       n_state = ST_ROW_RD;
                else if (r_qt != rd_t)   n_state = ST_DONE;
                else                     n_state = ST_COL0_RD;
            end
            ST_COL0_RD:  n_state = ST_COL0_CAP;
            ST_COL0_CAP: n_state = ST_COL_RD;
            ST_COL_RD:   n_state = ST_COL_CHK;
            ST_COL_CHK: begin
                if (p_hit)               n_state = r_last ? ST_MUL : ST_UPA_RD;
                else if (col_more)       n_state = ST_COL_RD;
                else if (r_qp != rd_p)   n_state = ST_DONE;
                else if (r_last)         n_state = ST_DONE;
                else                     n_state = ST_UPA_RD;
            end
            ST_UPA_RD:   n_state = ST_UPA_CAP;
            ST_UPA_CAP:  n_state = r_plin ? ST_MUL : ST_UPB_RD;
            ST_UPB_RD:   n_state = ST_UPB_CAP;
            ST_UPB_CAP:  n_state = ST_MUL;
            ST_MUL:      if (r_step == 3'd7) n_state = ST_DIV;
            ST_DIV:      if (r_dcnt == 4'd15) n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready  = (r_state == ST_IDLE);
        i_cfg.ready = 1'b1;
        unique case (r_state)
            ST_ROW_RD: ram_raddr = r_base + np_ext;
            ST_COL0_RD: ram_raddr = r_a;
            ST_COL_RD: ram_raddr = r_a + ADDR_W'(1);
            ST_UPA_RD: ram_raddr = r_a + np_ext;
            ST_UPB_RD: ram_raddr = r_a + np_ext + ADDR_W'(1);
            default:   ram_raddr = r_base;
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.density_out = r_out_d;
    assign o_out.status      = r_out_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_num_temps     <= NT_W'(2);
            r_num_pressures <= NP_W'(2);
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.reg_index == IDX_NUM_TEMPS) begin
                    r_num_temps <= i_cfg.reg_data[NT_W-1:0];
                end else begin
                    r_num_pressures <= i_cfg.reg_data;
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_qt    <= i_in.query_temperature;
                r_qp    <= i_in.query_pressure;
                r_nt    <= nt_clamp;
                r_np    <= np_clamp;
                r_base  <= '0;
                r_row   <= '0;
                r_col   <= '0;
                r_last  <= 1'b0;
                r_tlin  <= 1'b0;
                r_plin  <= 1'b0;
                r_step  <= '0;
                r_da    <= '0;
                r_db    <= '0;
                r_dc    <= '0;
                r_dd    <= '0;
                r_res_d <= '0;
                r_res_s <= STAT_OK;
            end
            ST_ROW0_CAP: r_t1 <= rd_t;
            ST_ROW_CHK: begin
                if (t_hit) begin
                    r_t2  <= rd_t;
                    r_a   <= r_base;
                end else begin
                    r_t1   <= rd_t;
                    r_base <= r_base + np_ext;
                    r_row  <= r_row + ROW_W'(1);
                    if (!row_more) begin
                        // last row: exact temperature match or outside
                        if (r_qt != rd_t) begin
                            r_res_s <= STAT_TEMP;
                        end else begin
                            r_last <= 1'b1;
                            r_tlin <= 1'b1;
                            r_a    <= r_base + np_ext;
                        end
                    end
                end
            end
            ST_COL0_CAP: begin
                r_p1 <= rd_p;
                r_da <= rd_d;
            end
            ST_COL_CHK: begin
                if (p_hit) begin
                    r_p2 <= rd_p;
                    r_db <= rd_d;
                end else begin
                    r_p1  <= rd_p;
                    r_da  <= rd_d;
                    r_a   <= r_a + ADDR_W'(1);
                    r_col <= r_col + COL_W'(1);
                    if (!col_more) begin
                        // last column: exact pressure match or outside
                        if (r_qp != rd_p) begin
                            r_res_s <= STAT_PRESS;
                        end else if (r_last) begin
                            r_res_d <= rd_d;
                        end else begin
                            r_plin <= 1'b1;
                        end
                    end
                end
            end
            ST_UPA_CAP: r_dc <= rd_d;
            ST_UPB_CAP: r_dd <= rd_d;
            ST_MUL: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd0: r_s   <= prod[32:0];
                    3'd1: r_s   <= r_s + prod[32:0];
                    3'd2: r_acc <= 51'(prod);
                    3'd3: r_s   <= prod[32:0];
                    3'd4: r_s   <= r_s + prod[32:0];
                    3'd5: r_acc <= r_acc + 51'(prod);
                    3'd6: r_den <= prod[31:0];
                    default: begin
                        r_num  <= r_acc + 51'(r_den >> 1);
                        r_dv   <= {4'b0, r_den, 15'b0};
                        r_q    <= '0;
                        r_dcnt <= '0;
                    end
                endcase
            end
            ST_DIV: begin
                // restoring divide, one quotient bit a cycle
                if (div_ge) begin
                    r_num <= r_num - r_dv;
                end
                r_q    <= {r_q[VAL_W-2:0], div_ge};
                r_dv   <= r_dv >> 1;
                r_dcnt <= r_dcnt + 4'd1;
                if (r_dcnt == 4'd15) begin
                    r_res_d <= {r_q[VAL_W-2:0], div_ge};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_d <= r_res_d;
                    r_out_s <= r_res_s;
                end
            end
            default: ;
        endcase
    end

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL && r_step == 3'd7 |=> r_state == ST_DIV)
        else $error("multiply sequence did not hand over to divider");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != STAT_OK |-> o_out.density_out == '0)
        else $error("error word carries nonzero density");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.func == FUNC_QUERY |=> r_state == ST_ROW0_RD)
        else $error("query did not start the row scan");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COL_CHK |-> (NP_W'({1'b0, r_col}) + NP_W'(2)) <= r_np)
        else $error("column scan ran past the row");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE && out_free |=> r_out_valid && r_state == ST_IDLE)
        else $error("finished word not placed in output register");

endmodule
`default_nettype wire

// ===== rtl/bgi_ram.sv =====
`default_nettype none
module bgi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
